[rtl/hit_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the hash intern table.
// Used by every module under rtl/ but hit_ram; depends on nothing.
package hit_pkg;

    // SLOTS must stay a power of two: the home slot is the low key bits.
    localparam int SLOTS        = 4096;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int BUFFER_BYTES = 1048576;
    localparam int KEY_W        = 64;
    localparam int LEN_W        = 21;
    localparam int OFF_W        = 20;
    localparam int STATUS_W     = 3;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic CMD_INTERN  = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STS_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_ZERO_KEY = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW = 3'd4;
    localparam logic [STATUS_W-1:0] STS_FOUND    = 3'd5;
    localparam logic [STATUS_W-1:0] STS_UNKNOWN  = 3'd6;

    localparam logic [1:0] KIND_INTERN       = 2'd0;
    localparam logic [1:0] KIND_RESOLVE      = 2'd1;
    localparam logic [1:0] KIND_ZERO_INTERN  = 2'd2;
    localparam logic [1:0] KIND_ZERO_RESOLVE = 2'd3;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] string_length;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    offset;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Slot entry: published offset is stored as offset+1, zero = none.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] offs;
    } t_slot;

endpackage

[rtl/hash_intern_table.sv]
`timescale 1ns / 1ps
// Top level of the hash intern table: front end, request queue, probe engine.
// Depends on hit_pkg, hit_front, hit_queue, hit_back (and hit_ram below it).
//
//   channel   direction   handshake                 payload
//   request   in          i_valid / o_stall         i_item (command, key, string_length)
//   result    out         o_valid / i_stall         o_item (status, offset)
//
// After reset the slot store is cleared one slot a cycle, with o_stall high.
// The engine registers a zero-key result on pop; for any other request it issues
// the home-slot read on pop, then probes one slot per cycle until a hit, an empty
// slot or the whole table is seen. The result sits in the output register until
// it is taken, and the next request is popped only once it is gone; the single
// read port of the slot RAM sets the probe rate.
// The two-entry queue keeps taking requests while a result waits on i_stall,
// until it holds two.
module hash_intern_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hit_pkg::t_in_item   i_item,
    output logic                o_stall,
    output logic                o_valid,
    output hit_pkg::t_out_item  o_item,
    input  logic                i_stall
);
    import hit_pkg::*;

    logic    push, pop, clr_done;
    t_job    push_job, head_job;
    t_q_stat q_stat;

    hit_front u_front (
        .i_valid    (i_valid),
        .i_item     (i_item),
        .o_stall    (o_stall),
        .i_q_stat   (q_stat),
        .i_clr_done (clr_done),
        .o_push     (push),
        .o_job      (push_job)
    );

    hit_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    hit_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (head_job),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_clr_done (clr_done),
        .o_valid    (o_valid),
        .o_item     (o_item),
        .i_stall    (i_stall)
    );
endmodule

[rtl/hit_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module hit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

[rtl/hit_front.sv]
`timescale 1ns / 1ps
// Front end: accepts requests, sorts out zero keys and fixes the length.
// Depends on hit_pkg; feeds hit_queue.
module hit_front (
    input  logic             i_valid,
    input  hit_pkg::t_in_item i_item,
    output logic             o_stall,
    input  hit_pkg::t_q_stat i_q_stat,
    input  logic             i_clr_done,
    output logic             o_push,
    output hit_pkg::t_job    o_job
);
    import hit_pkg::*;

    // Hold off while the slot store is being cleared or the queue is full.
    assign o_stall = !i_clr_done || i_q_stat.full;
    assign o_push  = i_valid && !o_stall;

    always_comb begin
        o_job.key = i_item.key;
        o_job.len = (i_item.string_length == '0) ? LEN_W'(1) : i_item.string_length;
        if (i_item.key == '0) begin
            o_job.kind = (i_item.command == CMD_RESOLVE) ? KIND_ZERO_RESOLVE
                                                         : KIND_ZERO_INTERN;
        end else begin
            o_job.kind = (i_item.command == CMD_RESOLVE) ? KIND_RESOLVE : KIND_INTERN;
        end
    end
endmodule

[rtl/hit_queue.sv]
`timescale 1ns / 1ps
// Short request queue between the front end and the probe engine.
// Depends on hit_pkg.
module hit_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hit_pkg::t_job    i_job,
    input  logic             i_pop,
    output hit_pkg::t_job    o_job,
    output hit_pkg::t_q_stat o_stat
);
    import hit_pkg::*;

    t_job              r_data [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb begin
        n_wptr  = i_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr  = i_pop  ? ptr_inc(r_rptr) : r_rptr;
        n_count = r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_data[r_wptr] <= i_job;
        end
    end

    assign o_job        = r_data[r_rptr];
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");
endmodule

[rtl/hit_back.sv]
`timescale 1ns / 1ps
// Probe engine: clears the slot store, walks the probe chain one slot a
// cycle, claims slots, advances the buffer head and holds the result.
// Depends on hit_pkg and hit_ram.
module hit_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hit_pkg::t_job      i_job,
    input  hit_pkg::t_q_stat   i_q_stat,
    output logic               o_pop,
    output logic               o_clr_done,
    output logic               o_valid,
    output hit_pkg::t_out_item o_item,
    input  logic               i_stall
);
    import hit_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    t_job              r_job, n_job;
    logic [LEN_W-1:0]  r_head, n_head;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    t_slot             wr_data;
    logic [SLOT_W-1:0] rd_addr;
    t_slot             rd_data;

    logic [SLOT_W-1:0] idx_next;
    logic [SLOT_W-1:0] home;
    logic              hit, empty, last;
    logic [LEN_W:0]    buf_end;
    logic              fits;

    hit_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign idx_next = (r_idx == SLOT_W'(SLOTS - 1)) ? '0 : r_idx + SLOT_W'(1);
    assign home     = i_job.key[SLOT_W-1:0];
    assign hit      = (rd_data.key == r_job.key);
    assign empty    = (rd_data.key == '0);
    assign last     = (r_cnt == SLOT_W'(SLOTS - 1));
    assign buf_end  = {1'b0, r_head} + {1'b0, r_job.len};
    assign fits     = (buf_end <= (LEN_W + 1)'(BUFFER_BYTES));

    // Issue the home slot read on pop, then the next slot every probe cycle.
    assign rd_addr = (r_state == S_IDLE) ? home : idx_next;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_job       = r_job;
        n_head      = r_head;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = '0;

        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_idx = idx_next;
                if (r_idx == SLOT_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_stat.empty && !r_out_valid) begin
                    o_pop = 1'b1;
                    case (i_job.kind)
                        KIND_ZERO_INTERN: begin
                            n_out_valid = 1'b1;
                            n_out       = '{status: STS_ZERO_KEY, offset: '0};
                        end
                        KIND_ZERO_RESOLVE: begin
                            n_out_valid = 1'b1;
                            n_out       = '{status: STS_UNKNOWN, offset: '0};
                        end
                        default: begin
                            n_job   = i_job;
                            n_idx   = home;
                            n_cnt   = '0;
                            n_state = S_PROBE;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (r_job.kind == KIND_INTERN) begin
                    if (hit) begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: STS_PRESENT, offset: '0};
                        n_state     = S_IDLE;
                    end else if (empty) begin
                        // Claim the slot; publish the offset only if it fits.
                        wr_en        = 1'b1;
                        wr_data.key  = r_job.key;
                        wr_data.offs = fits ? r_head + LEN_W'(1) : '0;
                        n_head       = fits ? buf_end[LEN_W-1:0] : LEN_W'(BUFFER_BYTES);
                        n_out_valid  = 1'b1;
                        n_out.status = fits ? STS_INSERTED : STS_OVERFLOW;
                        n_out.offset = fits ? r_head[OFF_W-1:0] : '0;
                        n_state      = S_IDLE;
                    end else if (last) begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: STS_FULL, offset: '0};
                        n_state     = S_IDLE;
                    end else begin
                        n_idx = idx_next;
                        n_cnt = r_cnt + SLOT_W'(1);
                    end
                end else begin
                    if (hit) begin
                        n_out_valid = 1'b1;
                        if (rd_data.offs == '0) begin
                            n_out = '{status: STS_UNKNOWN, offset: '0};
                        end else begin
                            n_out.status = STS_FOUND;
                            n_out.offset = OFF_W'(rd_data.offs - LEN_W'(1));
                        end
                        n_state = S_IDLE;
                    end else if (empty || last) begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: STS_UNKNOWN, offset: '0};
                        n_state     = S_IDLE;
                    end else begin
                        n_idx = idx_next;
                        n_cnt = r_cnt + SLOT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
        r_job <= n_job;
        r_out <= n_out;
    end

    assign o_clr_done = (r_state != S_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_out_valid && r_state == S_IDLE))
        else $error("request popped while a result is pending");
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LEN_W'(BUFFER_BYTES))
        else $error("buffer head beyond buffer size");
    a_probe_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> !r_out_valid)
        else $error("probing with an undelivered result");
    a_result_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && n_out_valid) |=> (r_state == S_IDLE))
        else $error("probe did not end with its result");
endmodule

[tb/tb_hash_intern_table.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hash_intern_table: queue-fed driver, clocked monitor, and a
// shadow model of the slot table and buffer head that predicts every result in order.
// Depends on hit_pkg and the RTL under rtl/.
module tb_hash_intern_table;
    import hit_pkg::*;

    localparam int CLK_HI         = 6;
    localparam int CLK_LO         = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4 * SLOTS + 4000;
    localparam int TAIL_CYCLES    = 64;
    localparam int RANDOM_CHUNK   = 250;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_item  = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;

    hash_intern_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

    always begin
        #CLK_HI i_clk = 1'b1;
        #CLK_LO i_clk = 1'b0;
    end

    // Shadow copy of the table state.
    bit [KEY_W-1:0] slot_key [SLOTS];
    bit [LEN_W-1:0] slot_pub [SLOTS];
    int unsigned    buf_head = 0;

    t_in_item       req_queue [$];
    t_out_item      result_queue [$];
    logic [KEY_W-1:0] key_pool [$];

    int  queued_total   = 0;
    int  accepted_total = 0;
    int  results_seen   = 0;
    int  errors         = 0;
    int  idle_cycles    = 0;
    int  status_seen [8];
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  req_taken      = 1'b0;
    bit  hold_ask       = 1'b0;
    bit  hold_used      = 1'b0;
    int  hold_left      = 0;

    function automatic t_out_item predict_result(t_in_item req);
        t_out_item         res;
        logic [SLOT_W-1:0] idx;
        int unsigned       len;
        int unsigned       off;
        int unsigned       end_pos;
        int                n;
        res = '0;
        if (req.key == '0) begin
            res.status = (req.command == CMD_INTERN) ? STS_ZERO_KEY : STS_UNKNOWN;
            return res;
        end
        idx = req.key[SLOT_W-1:0];
        if (req.command == CMD_INTERN) begin
            len = (req.string_length == '0) ? 1 : req.string_length;
            res.status = STS_FULL;
            for (n = 0; n < SLOTS; n++) begin
                if (slot_key[idx] == req.key) begin
                    res.status = STS_PRESENT;
                    return res;
                end
                if (slot_key[idx] == '0) begin
                    off     = buf_head;
                    end_pos = off + len;
                    slot_key[idx] = req.key;
                    buf_head = (end_pos > BUFFER_BYTES) ? BUFFER_BYTES : end_pos;
                    if (end_pos > BUFFER_BYTES) begin
                        res.status = STS_OVERFLOW;
                    end else begin
                        slot_pub[idx] = LEN_W'(off + 1);
                        res.status    = STS_INSERTED;
                        res.offset    = OFF_W'(off);
                    end
                    return res;
                end
                idx = idx + 1'b1;
            end
            return res;
        end
        res.status = STS_UNKNOWN;
        for (n = 0; n < SLOTS; n++) begin
            if (slot_key[idx] == req.key) begin
                if (slot_pub[idx] != '0) begin
                    res.status = STS_FOUND;
                    res.offset = OFF_W'(slot_pub[idx] - 1'b1);
                end
                return res;
            end
            if (slot_key[idx] == '0) return res;
            idx = idx + 1'b1;
        end
        return res;
    endfunction

    // Request side: predict on acceptance, then drive the next request at the falling edge.
    always @(posedge i_clk) begin
        req_taken = i_rst_n && i_valid && !o_stall;
        if (req_taken) begin
            result_queue.push_back(predict_result(i_item));
            accepted_total++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_valid || req_taken) begin
            if (req_queue.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
                i_item  <= req_queue.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side stall, with one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_ask && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (result_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status=%0d offset=%0h",
                         $time, o_item.status, o_item.offset);
            end else begin
                t_out_item want;
                want = result_queue.pop_front();
                if (o_item.status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, o_item.status);
                end
                if (o_item.offset !== want.offset) begin
                    errors++;
                    $display("%0t: offset mismatch expected %0h actual %0h",
                             $time, want.offset, o_item.offset);
                end
            end
            if (!$isunknown(o_item.status)) status_seen[o_item.status]++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_req(logic cmd, logic [KEY_W-1:0] key, logic [LEN_W-1:0] len);
        t_in_item req;
        req.command       = cmd;
        req.key           = key;
        req.string_length = len;
        req_queue.push_back(req);
        queued_total++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (accepted_total != queued_total || result_queue.size() != 0);
    endtask

    // New key: fully random, or pinned near the wrap point to build probe clusters.
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        do begin
            k = {$urandom, $urandom};
            if ($urandom_range(0, 9) < 3)
                k[SLOT_W-1:0] = SLOT_W'(SLOTS - 8 + $urandom_range(0, 15));
        end while (k == '0);
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] pool_key();
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    task automatic push_random(int count);
        int               pick;
        logic [KEY_W-1:0] k;
        logic [LEN_W-1:0] len;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 4095))
                                                : LEN_W'($urandom_range(0, 255));
            if (pick < 35) begin
                k = fresh_key();
                key_pool.push_back(k);
                push_req(CMD_INTERN, k, len);
            end else if (pick < 50) begin
                push_req(CMD_INTERN, pool_key(), len);
            end else if (pick < 80) begin
                push_req(CMD_RESOLVE, pool_key(), LEN_W'($urandom));
            end else if (pick < 92) begin
                push_req(CMD_RESOLVE, fresh_key(), LEN_W'($urandom));
            end else if (pick < 96) begin
                push_req(CMD_INTERN, '0, len);
            end else begin
                push_req(CMD_RESOLVE, '0, LEN_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [KEY_W-1:0] k_a;
        logic [KEY_W-1:0] k_b;
        logic [KEY_W-1:0] k_c;
        logic [KEY_W-1:0] k_ovf;
        logic [KEY_W-1:0] k_fit;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: wrap from the last slot, collisions, zero length, zero key, hits, misses.
        k_a = {$urandom, $urandom};
        k_a[SLOT_W-1:0] = '1;
        k_b = k_a ^ (64'h1 << 40);
        k_c = {$urandom, $urandom};
        k_c[SLOT_W-1:0] = '0;
        k_c[KEY_W-1] = 1'b1;
        push_req(CMD_INTERN, k_a, 21'd10);
        push_req(CMD_INTERN, k_b, 21'd0);
        push_req(CMD_INTERN, k_c, 21'd5);
        push_req(CMD_INTERN, '1, 21'd1);
        push_req(CMD_INTERN, 64'h1, 21'd1);
        push_req(CMD_INTERN, k_a, 21'd7);
        push_req(CMD_INTERN, '0, 21'd3);
        push_req(CMD_RESOLVE, '0, '1);
        push_req(CMD_RESOLVE, k_a, '0);
        push_req(CMD_RESOLVE, k_b, '1);
        push_req(CMD_RESOLVE, k_c, 21'd1);
        push_req(CMD_RESOLVE, '1, 21'd2);
        push_req(CMD_RESOLVE, 64'h1, 21'd0);
        push_req(CMD_RESOLVE, k_a ^ (64'h1 << 63), 21'd0);
        push_req(CMD_RESOLVE, 64'h8000_0000_0000_0000, 21'd0);
        push_req(CMD_RESOLVE, 64'h1000, 21'd0);
        key_pool.push_back(k_a);
        key_pool.push_back(k_b);
        key_pool.push_back(k_c);
        key_pool.push_back('1);
        key_pool.push_back(64'h1);
        wait_drained();

        // Random: no idling with one long result hold-off, then the idle mixes.
        push_random(RANDOM_CHUNK);
        hold_ask = 1'b1;
        wait_drained();
        send_idle_pct = 67;
        push_random(RANDOM_CHUNK);
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        push_random(RANDOM_CHUNK);
        wait_drained();
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        push_random(RANDOM_CHUNK);
        wait_drained();

        // Exhaust the buffer: exact fit, then claimed-but-unpublished keys.
        k_fit = fresh_key();
        k_ovf = fresh_key();
        push_req(CMD_INTERN, k_fit, LEN_W'(BUFFER_BYTES - buf_head));
        push_req(CMD_INTERN, k_ovf, 21'd1);
        push_req(CMD_INTERN, k_ovf, 21'd1);
        push_req(CMD_RESOLVE, k_ovf, 21'd0);
        push_req(CMD_RESOLVE, k_fit, 21'd0);
        push_req(CMD_INTERN, fresh_key(), '1);
        push_req(CMD_INTERN, fresh_key(), 21'd0);
        push_req(CMD_INTERN, fresh_key(), LEN_W'(BUFFER_BYTES));
        key_pool.push_back(k_fit);
        key_pool.push_back(k_ovf);
        wait_drained();

        // Exhausted buffer: new keys overflow, known keys still hit and resolve.
        push_req(CMD_INTERN, fresh_key(), 21'd4);
        push_req(CMD_RESOLVE, fresh_key(), 21'd0);
        push_req(CMD_INTERN, pool_key(), 21'd4);
        push_req(CMD_RESOLVE, pool_key(), 21'd0);
        push_req(CMD_RESOLVE, k_fit, 21'd0);
        push_req(CMD_INTERN, '0, 21'd0);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (result_queue.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, result_queue.size());
        end

        $display("Ran %0d requests, %0d results: directed, idle mixes, hold-off, buffer full",
                 accepted_total, results_seen);
        $display("Status counts ins %0d pres %0d zero %0d ovf %0d found %0d unk %0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
